FILE: hdl/perac_pkg.sv
// Shared widths, event and action codes, register indexes and the
// controller/datapath command and status bundles. No dependencies.
package perac_pkg;

	localparam int TYPE_W  = 16;
	localparam int CODE_W  = 16;
	localparam int VAL_W   = 32;
	localparam int KIND_W  = 3;
	localparam int POS_W   = 13;
	localparam int SCR_W   = 14;
	localparam int BTN_W   = 3;
	localparam int Q_W     = SCR_W;            // quotient < screen - 1
	localparam int PROD_W  = VAL_W + SCR_W;
	localparam int CFG_IDX_W = 3;

	localparam int PENDING_DEPTH = 8;

	// evdev event types
	localparam logic [TYPE_W-1:0] EV_SYN = 16'd0;
	localparam logic [TYPE_W-1:0] EV_KEY = 16'd1;
	localparam logic [TYPE_W-1:0] EV_REL = 16'd2;
	localparam logic [TYPE_W-1:0] EV_ABS = 16'd3;

	// evdev codes
	localparam logic [CODE_W-1:0] CODE_ABS_X   = 16'h0000;
	localparam logic [CODE_W-1:0] CODE_ABS_Y   = 16'h0001;
	localparam logic [CODE_W-1:0] CODE_BTN_LEFT = 16'h0110;
	localparam logic [CODE_W-1:0] CODE_BTN_MIDDLE = 16'h0112;
	localparam logic [CODE_W-1:0] CODE_REL_WHEEL = 16'h0008;

	// action kinds
	localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BTN0  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WHEEL = 3'd7;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ABS_MIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_MAX_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_MIN_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ABS_MAX_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

	typedef struct packed {
		logic accept;       // input transfer this cycle
		logic sel_y;        // axis being scaled
		logic setup;        // latch scaling operands
		logic mul;          // register the product
		logic div_start;
		logic store;        // latch scaled position
		logic emit_move;
		logic emit_queue;
	} perac_cmd_t;

	typedef struct packed {
		logic syn_work;     // incoming event is SYN with something to report
		logic moved;
		logic q_empty;
		logic drain_last;
		logic div_busy;
		logic out_free;
	} perac_sts_t;

endpackage

FILE: hdl/perac_div.sv
// Restoring divider, one quotient bit per cycle, for the position scaling.
// Depends on perac_pkg.
module perac_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [perac_pkg::PROD_W-1:0] dividend,
	input  logic [perac_pkg::VAL_W-1:0]  divisor,
	output logic [perac_pkg::Q_W-1:0]    quotient,
	output logic                         busy
);
	import perac_pkg::*;

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [VAL_W-1:0] rem_q;
	logic [Q_W-1:0]   num_q;
	logic [Q_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W:0]   trial;
	logic [VAL_W:0]   diff;
	logic             ge;

	// quotient is known to fit Q_W bits, so the top bits seed the remainder
	assign trial = {rem_q, num_q[Q_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(Q_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:Q_W];
			num_q <= dividend[Q_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			num_q <= {num_q[Q_W-2:0], 1'b0};
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign busy     = cnt_q != '0;

endmodule

FILE: hdl/perac_dp.sv
// Datapath: config registers, axis and button state, pending action queue,
// scaling pipeline around the divider, and the output register.
// Depends on perac_pkg and perac_div.
module perac_dp #(
	parameter int MAX_PENDING = perac_pkg::PENDING_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  perac_pkg::perac_cmd_t           cmd,
	output perac_pkg::perac_sts_t           sts,
	input  logic                            cfg_we,
	input  logic [perac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [perac_pkg::VAL_W-1:0]     cfg_data,
	input  logic [perac_pkg::TYPE_W-1:0]    event_type,
	input  logic [perac_pkg::CODE_W-1:0]    event_code,
	input  logic signed [perac_pkg::VAL_W-1:0] event_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [perac_pkg::KIND_W-1:0]    action_kind,
	output logic [perac_pkg::POS_W-1:0]     pos_x,
	output logic [perac_pkg::POS_W-1:0]     pos_y,
	output logic signed [perac_pkg::VAL_W-1:0] wheel_amount,
	output logic [perac_pkg::BTN_W-1:0]     held_buttons,
	output logic                            last_of_report
);
	import perac_pkg::*;

	localparam int CNT_W = $clog2(MAX_PENDING + 1);
	localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

	function automatic logic [POS_W-1:0] sat_pos(input logic [Q_W-1:0] v);
		sat_pos = (v > Q_W'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
	endfunction

	// configuration
	logic [VAL_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [SCR_W-1:0] scr_w_q, scr_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			max_x_q <= VAL_W'(32767);
			min_y_q <= '0;
			max_y_q <= VAL_W'(32767);
			scr_w_q <= SCR_W'(1024);
			scr_h_q <= SCR_W'(768);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ABS_MIN_X:     min_x_q <= cfg_data;
				REG_ABS_MAX_X:     max_x_q <= cfg_data;
				REG_ABS_MIN_Y:     min_y_q <= cfg_data;
				REG_ABS_MAX_Y:     max_y_q <= cfg_data;
				REG_SCREEN_WIDTH:  scr_w_q <= cfg_data[SCR_W-1:0];
				REG_SCREEN_HEIGHT: scr_h_q <= cfg_data[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	// event decode
	logic             is_abs_x, is_abs_y, is_btn, is_wheel, btn_down, q_push;
	logic [1:0]       btn_idx;
	logic [KIND_W-1:0] push_kind;
	logic [VAL_W-1:0] wheel_val;
	logic [BTN_W-1:0] btn_bit;

	logic [VAL_W-1:0] axis_x_q, axis_y_q;
	logic             moved_q;
	logic [BTN_W-1:0] mask_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] drain_q;

	always_comb begin
		is_abs_x  = event_type == EV_ABS && event_code == CODE_ABS_X;
		is_abs_y  = event_type == EV_ABS && event_code == CODE_ABS_Y;
		is_btn    = event_type == EV_KEY && event_code >= CODE_BTN_LEFT
		            && event_code <= CODE_BTN_MIDDLE;
		is_wheel  = event_type == EV_REL && event_code == CODE_REL_WHEEL;
		btn_idx   = event_code[1:0];
		btn_down  = event_value != '0;
		btn_bit   = BTN_W'(1) << btn_idx;
		// times 120 as 128 - 8, wraps at 32 bits
		wheel_val = (VAL_W'(event_value) << 7) - (VAL_W'(event_value) << 3);
		push_kind = is_wheel ? KIND_WHEEL
		            : KIND_BTN0 + {btn_idx, 1'b0} + {2'b00, !btn_down};
		q_push    = cmd.accept && (is_btn || is_wheel)
		            && count_q < CNT_W'(MAX_PENDING);
	end

	// pending queue storage
	logic [KIND_W-1:0] q_kind [MAX_PENDING];
	logic [VAL_W-1:0]  q_amt  [MAX_PENDING];

	always_ff @(posedge clk) begin
		if (q_push) begin
			q_kind[count_q[IDX_W-1:0]] <= push_kind;
			q_amt[count_q[IDX_W-1:0]]  <= is_wheel ? wheel_val : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= '0;
			axis_y_q <= '0;
			moved_q  <= 1'b0;
			mask_q   <= '0;
			count_q  <= '0;
			drain_q  <= '0;
		end else begin
			if (cmd.accept && is_abs_x) begin
				axis_x_q <= VAL_W'(event_value);
				moved_q  <= 1'b1;
			end
			if (cmd.accept && is_abs_y) begin
				axis_y_q <= VAL_W'(event_value);
				moved_q  <= 1'b1;
			end
			if (cmd.accept && is_btn) begin
				mask_q <= btn_down ? (mask_q | btn_bit) : (mask_q & ~btn_bit);
			end
			if (q_push) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.emit_move) begin
				moved_q <= 1'b0;
			end
			if (cmd.accept && event_type == EV_SYN) begin
				drain_q <= '0;
			end
			if (cmd.emit_queue) begin
				drain_q <= drain_q + 1'b1;
				if (sts.drain_last) begin
					count_q <= '0;
				end
			end
		end
	end

	// scaling: setup -> multiply -> divide -> store
	logic [VAL_W-1:0]  diff_s1, den_s1;
	logic [SCR_W-1:0]  scm1_s1;
	logic              zero_s1, high_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [Q_W-1:0]    quo;
	logic              div_busy;
	logic [POS_W-1:0]  scaled;
	logic [POS_W-1:0]  last_x_q, last_y_q;
	logic [VAL_W-1:0]  v_sel, lo_sel, hi_sel;
	logic [SCR_W-1:0]  scr_sel;

	always_comb begin
		v_sel   = cmd.sel_y ? axis_y_q : axis_x_q;
		lo_sel  = cmd.sel_y ? min_y_q  : min_x_q;
		hi_sel  = cmd.sel_y ? max_y_q  : max_x_q;
		scr_sel = cmd.sel_y ? scr_h_q  : scr_w_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			diff_s1 <= v_sel - lo_sel;
			den_s1  <= hi_sel - lo_sel;
			scm1_s1 <= scr_sel - 1'b1;
			zero_s1 <= (hi_sel <= lo_sel) || (scr_sel == '0) || (v_sel <= lo_sel);
			high_s1 <= v_sel >= hi_sel;
		end
		if (cmd.mul) begin
			prod_s2 <= PROD_W'(diff_s1) * PROD_W'(scm1_s1);
		end
	end

	perac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_s2),
		.divisor  (den_s1),
		.quotient (quo),
		.busy     (div_busy)
	);

	always_comb begin
		if (zero_s1) begin
			scaled = '0;
		end else if (high_s1) begin
			scaled = sat_pos(scm1_s1);
		end else begin
			scaled = sat_pos(quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (cmd.store) begin
			if (cmd.sel_y) begin
				last_y_q <= scaled;
			end else begin
				last_x_q <= scaled;
			end
		end
	end

	// output register
	logic [KIND_W-1:0] rd_kind;
	logic [VAL_W-1:0]  rd_amt;
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [POS_W-1:0]  px_q, py_q;
	logic [VAL_W-1:0]  amt_q;
	logic [BTN_W-1:0]  held_q;
	logic              last_q;

	assign rd_kind = q_kind[drain_q[IDX_W-1:0]];
	assign rd_amt  = q_amt[drain_q[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_move || cmd.emit_queue) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_move) begin
			kind_q <= KIND_MOVE;
			px_q   <= last_x_q;
			py_q   <= last_y_q;
			amt_q  <= '0;
			held_q <= mask_q;
			last_q <= count_q == '0;
		end else if (cmd.emit_queue) begin
			kind_q <= rd_kind;
			px_q   <= '0;
			py_q   <= '0;
			amt_q  <= (rd_kind == KIND_WHEEL) ? rd_amt : '0;
			held_q <= mask_q;
			last_q <= sts.drain_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign action_kind    = kind_q;
	assign pos_x          = px_q;
	assign pos_y          = py_q;
	assign wheel_amount   = amt_q;
	assign held_buttons   = held_q;
	assign last_of_report = last_q;

	always_comb begin
		sts.syn_work   = event_type == EV_SYN && (moved_q || count_q != '0);
		sts.moved      = moved_q;
		sts.q_empty    = count_q == '0;
		sts.drain_last = drain_q == count_q - 1'b1;
		sts.div_busy   = div_busy;
		sts.out_free   = !out_valid_q || !out_stall;
	end

endmodule

FILE: hdl/perac_ctrl.sv
// Report sequencer: when an axis moved, scales X then Y and emits the move
// item; then drains the pending queue if it holds actions. Depends on perac_pkg.
module perac_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  perac_pkg::perac_sts_t sts,
	output perac_pkg::perac_cmd_t cmd
);
	import perac_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_MUL,
		S_DIVST,
		S_DIV,
		S_STORE,
		S_MOVE,
		S_DRAIN
	} state_t;

	state_t state_q;
	logic   sel_y_q;
	logic   accept;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_y_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && sts.syn_work) begin
						sel_y_q <= 1'b0;
						state_q <= sts.moved ? S_SETUP : S_DRAIN;
					end
				end
				S_SETUP: state_q <= S_MUL;
				S_MUL:   state_q <= S_DIVST;
				S_DIVST: state_q <= S_DIV;
				S_DIV: begin
					if (!sts.div_busy) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (sel_y_q) begin
						state_q <= S_MOVE;
					end else begin
						sel_y_q <= 1'b1;
						state_q <= S_SETUP;
					end
				end
				S_MOVE: begin
					if (sts.out_free) begin
						state_q <= sts.q_empty ? S_IDLE : S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (sts.out_free && sts.drain_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.sel_y      = sel_y_q;
		cmd.setup      = state_q == S_SETUP;
		cmd.mul        = state_q == S_MUL;
		cmd.div_start  = state_q == S_DIVST;
		cmd.store      = state_q == S_STORE;
		cmd.emit_move  = state_q == S_MOVE && sts.out_free;
		cmd.emit_queue = state_q == S_DRAIN && sts.out_free;
	end

endmodule

FILE: hdl/pointer_event_report_assembler_core.sv
// Top level of the pointer event report assembler: controller plus datapath.
// Depends on perac_pkg, perac_ctrl and perac_dp (which holds perac_div).
//
// Consumes evdev events from an absolute tablet and builds pointer reports.
// ABS X/Y, button (left/right/middle) and wheel events are taken with no
// stall: the axes and held-button mask update at once, and button or wheel
// actions go into a queue of MAX_PENDING entries; when it is full the action
// is dropped but the mask still follows the button. A SYN with nothing to
// report is a no-op. A SYN with work produces a report: one move item
// (only if an axis event arrived since the last report) and then the queued
// actions in arrival order, with last_of_report set on the final item.
// Scaling: the move position is scaled per axis with a setup step, a
// 32x14 multiply, a divider start step, a restoring division, a wait
// for the divider to finish, and a store, X then Y on one shared
// divider. Each item is then loaded into the output register when the
// output side is not stalling, the move item first and then the queued
// actions; output stalls hold this sequence. A report without motion
// skips the scaling and goes straight to the queued actions.
// in_stall stays high from the SYN transfer until the final item has been
// loaded into the output register; the last item can still be waiting there
// while the next event is taken. Position rules: a degenerate range
// (max <= min) or a zero screen size gives 0, an axis at or below min
// gives 0, at or above max gives screen - 1, and anything above 8191
// saturates. Wheel items carry detents times 120, wrapping at 32 bits.
// Config registers (index 0..5: abs_min_x, abs_max_x, abs_min_y, abs_max_y,
// screen_width, screen_height) take effect on write; indexes 6 and 7 are
// ignored. Write them only while the block is idle.
module pointer_event_report_assembler_core #(
	parameter int MAX_PENDING = perac_pkg::PENDING_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [perac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [perac_pkg::VAL_W-1:0]        cfg_data,
	// event input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [perac_pkg::TYPE_W-1:0]       event_type,
	input  logic [perac_pkg::CODE_W-1:0]       event_code,
	input  logic signed [perac_pkg::VAL_W-1:0] event_value,
	// report output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [perac_pkg::KIND_W-1:0]       action_kind,
	output logic [perac_pkg::POS_W-1:0]        pos_x,
	output logic [perac_pkg::POS_W-1:0]        pos_y,
	output logic signed [perac_pkg::VAL_W-1:0] wheel_amount,
	output logic [perac_pkg::BTN_W-1:0]        held_buttons,
	output logic                               last_of_report
);
	import perac_pkg::*;

	perac_cmd_t cmd;   // controller -> datapath
	perac_sts_t sts;   // datapath -> controller

	// sequencer: owns in_stall and the per-report step order
	perac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// all storage, scaling arithmetic and the output register
	perac_dp #(
		.MAX_PENDING (MAX_PENDING)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.event_type     (event_type),
		.event_code     (event_code),
		.event_value    (event_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action_kind    (action_kind),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.wheel_amount   (wheel_amount),
		.held_buttons   (held_buttons),
		.last_of_report (last_of_report)
	);

endmodule
